// ===== hw/rtl/uvs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uvs_pkg
// Shared types and constants of the UV sphere vertex and index generator.
// ----------------------------------------------------------------------------
package uvs_pkg;

   localparam int MAX_DIVISIONS   = 256;
   localparam int COORD_FRAC_BITS = 14;

   localparam logic [8:0] SECTOR_RESET = 9'd36;
   localparam logic [8:0] STACK_RESET  = 9'd18;
   localparam logic [8:0] SECTOR_MIN   = 9'd3;
   localparam logic [8:0] STACK_MIN    = 9'd2;
   localparam logic [8:0] COUNT_MAX    = 9'(MAX_DIVISIONS);

   // register indexes of the configuration port
   localparam logic CSR_SECTOR_COUNT = 1'b0;
   localparam logic CSR_STACK_COUNT  = 1'b1;

   // pipelined long division
   localparam int DIV_WIDTH  = 42;
   localparam int DIV_STEPS  = 7;
   localparam int DIV_STAGES = DIV_WIDTH / DIV_STEPS;

   // cordic
   localparam int CORDIC_ITERS = 30;
   localparam int CORDIC_LAT   = CORDIC_ITERS + 2;
   localparam logic signed [31:0] GAIN_INV = 32'sd652032874;
   localparam logic signed [31:0] ONE30    = 32'sh4000_0000;
   localparam logic [31:0] LAT_TOP_PHASE   = 32'h4000_0000;

   localparam logic [31:0] ATAN_TURNS [CORDIC_ITERS] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
      32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
      32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001
   };

   // sideband from capture to output register
   localparam int SB_DEPTH = DIV_STAGES + CORDIC_LAT + 1;

   typedef struct packed {
      logic [8:0]           rem;
      logic [DIV_WIDTH-1:0] work;
   } div_state_type;

   typedef struct packed {
      logic        in_range;
      logic        quad;
      logic        upper;
      logic        lower;
      logic [16:0] k1;
   } sideband_type;

   function automatic div_state_type div_steps(div_state_type st, logic [8:0] divisor);
      logic [9:0]    t;
      div_state_type r;
      r = st;
      for (int n = 0; n < DIV_STEPS; n++) begin
         t = {r.rem, r.work[DIV_WIDTH-1]};
         if (t >= {1'b0, divisor}) begin
            r.rem  = 9'(t - {1'b0, divisor});
            r.work = {r.work[DIV_WIDTH-2:0], 1'b1};
         end else begin
            r.rem  = t[8:0];
            r.work = {r.work[DIV_WIDTH-2:0], 1'b0};
         end
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/uvs_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uvs_divider
// Pipelined restoring divider, several quotient bits per stage.
// ----------------------------------------------------------------------------
module uvs_divider import uvs_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 advance,
   input  wire logic [8:0]           divisor,
   input  wire logic [DIV_WIDTH-1:0] dividend,
   output logic      [31:0]          quotient
);

   div_state_type st_ff [DIV_STAGES];

   always_ff @(posedge clock) begin
      if (advance) begin
         st_ff[0] <= div_steps('{rem: 9'd0, work: dividend}, divisor);
      end
   end

   for (genvar s = 1; s < DIV_STAGES; s++) begin : g_stage
      always_ff @(posedge clock) begin
         if (advance) begin
            st_ff[s] <= div_steps(st_ff[s-1], divisor);
         end
      end
   end

   assign quotient = st_ff[DIV_STAGES-1].work[31:0];

endmodule
`default_nettype wire

// ===== hw/rtl/uvs_cordic.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uvs_cordic
// Pipelined rotation-mode cordic, one iteration per stage, sine and cosine
// of a 32-bit phase scaled by 2^30.
// ----------------------------------------------------------------------------
module uvs_cordic import uvs_pkg::*; (
   input  wire logic               clock,
   input  wire logic               advance,
   input  wire logic [31:0]        phase,
   output logic signed [31:0]      cos_out,
   output logic signed [31:0]      sin_out
);

   logic signed [31:0] x_ff [CORDIC_ITERS+1];
   logic signed [31:0] y_ff [CORDIC_ITERS+1];
   logic signed [31:0] z_ff [CORDIC_ITERS+1];
   logic [1:0]         quad_ff [CORDIC_ITERS+1];
   logic               zero_ff [CORDIC_ITERS+1];
   logic signed [31:0] cos_ff;
   logic signed [31:0] sin_ff;
   logic signed [31:0] c_in;
   logic signed [31:0] s_in;

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff[0]    <= GAIN_INV;
         y_ff[0]    <= '0;
         z_ff[0]    <= $signed({2'b00, phase[29:0]});
         quad_ff[0] <= phase[31:30];
         zero_ff[0] <= (phase[29:0] == 30'd0);
      end
   end

   for (genvar k = 0; k < CORDIC_ITERS; k++) begin : g_iter
      always_ff @(posedge clock) begin
         if (advance) begin
            quad_ff[k+1] <= quad_ff[k];
            zero_ff[k+1] <= zero_ff[k];
            if (!z_ff[k][31]) begin
               x_ff[k+1] <= x_ff[k] - (y_ff[k] >>> k);
               y_ff[k+1] <= y_ff[k] + (x_ff[k] >>> k);
               z_ff[k+1] <= z_ff[k] - $signed(ATAN_TURNS[k]);
            end else begin
               x_ff[k+1] <= x_ff[k] + (y_ff[k] >>> k);
               y_ff[k+1] <= y_ff[k] - (x_ff[k] >>> k);
               z_ff[k+1] <= z_ff[k] + $signed(ATAN_TURNS[k]);
            end
         end
      end
   end

   // exact values on the axes
   assign c_in = zero_ff[CORDIC_ITERS] ? ONE30 : x_ff[CORDIC_ITERS];
   assign s_in = zero_ff[CORDIC_ITERS] ? 32'sd0 : y_ff[CORDIC_ITERS];

   always_ff @(posedge clock) begin
      if (advance) begin
         case (quad_ff[CORDIC_ITERS])
            2'd0: begin
               cos_ff <= c_in;
               sin_ff <= s_in;
            end
            2'd1: begin
               cos_ff <= -s_in;
               sin_ff <= c_in;
            end
            2'd2: begin
               cos_ff <= -c_in;
               sin_ff <= -s_in;
            end
            default: begin
               cos_ff <= s_in;
               sin_ff <= -c_in;
            end
         endcase
      end
   end

   assign cos_out = cos_ff;
   assign sin_out = sin_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/uvs_coord.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uvs_coord
// Position products, rounding and saturation to the output fixed point.
// ----------------------------------------------------------------------------
module uvs_coord import uvs_pkg::*; (
   input  wire logic               clock,
   input  wire logic               advance,
   input  wire logic signed [31:0] cos_lat,
   input  wire logic signed [31:0] sin_lat,
   input  wire logic signed [31:0] cos_lon,
   input  wire logic signed [31:0] sin_lon,
   output logic        [15:0]      pos_x,
   output logic        [15:0]      pos_y,
   output logic        [15:0]      pos_z
);

   localparam int XY_SHIFT = 60 - COORD_FRAC_BITS;
   localparam int Z_SHIFT  = 30 - COORD_FRAC_BITS;
   localparam logic signed [63:0] XY_HALF = 64'sd1 <<< (XY_SHIFT - 1);
   localparam logic signed [63:0] Z_HALF  = 64'sd1 <<< (Z_SHIFT - 1);
   localparam logic signed [63:0] LIM     = 64'sd1 <<< COORD_FRAC_BITS;

   logic signed [63:0] px_ff;
   logic signed [63:0] py_ff;
   logic signed [31:0] pz_ff;
   logic signed [63:0] xr;
   logic signed [63:0] yr;
   logic signed [63:0] zr;

   function automatic logic [15:0] sat_coord(logic signed [63:0] v);
      logic signed [63:0] r;
      if (v > LIM) begin
         r = LIM;
      end else if (v < -LIM) begin
         r = -LIM;
      end else begin
         r = v;
      end
      return r[15:0];
   endfunction

   always_ff @(posedge clock) begin
      if (advance) begin
         px_ff <= cos_lat * cos_lon;
         py_ff <= cos_lat * sin_lon;
         pz_ff <= sin_lat;
      end
   end

   assign xr = (px_ff + XY_HALF) >>> XY_SHIFT;
   assign yr = (py_ff + XY_HALF) >>> XY_SHIFT;
   assign zr = (64'(pz_ff) + Z_HALF) >>> Z_SHIFT;

   assign pos_x = sat_coord(xr);
   assign pos_y = sat_coord(yr);
   assign pos_z = sat_coord(zr);

endmodule
`default_nettype wire

// ===== hw/rtl/uv_sphere_vertex_index_generator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uv_sphere_vertex_index_generator
// Vertex position and quad corner indices of one grid point of a UV sphere.
// ----------------------------------------------------------------------------
// Takes one grid point per clock while the output is not stalled and returns
// one result per point, in order. The point lands in the capture register at
// the edge that takes it. From there it passes a six-stage divider that turns
// row and column into angle phases, a 32-stage cordic pipeline (an input
// stage, one rotation per stage and the quadrant stage), the product stage and
// the output register. When the output is stalled the whole pipeline holds.
// Counts written out of range are clamped, sectors to 3..256 and stacks to
// 2..256.
module uv_sphere_vertex_index_generator import uvs_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [8:0]  req_stack_row,
   input  wire logic [8:0]  req_sector_column,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [15:0]      rsp_pos_x,
   output logic [15:0]      rsp_pos_y,
   output logic [15:0]      rsp_pos_z,
   output logic             rsp_in_range,
   output logic             rsp_upper_triangle_valid,
   output logic             rsp_lower_triangle_valid,
   output logic [16:0]      rsp_corner_top_left,
   output logic [16:0]      rsp_corner_bottom_left,
   output logic [16:0]      rsp_corner_top_right,
   output logic [16:0]      rsp_corner_bottom_right,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [8:0]  csr_data
);

   logic [8:0]         sector_ff;
   logic [8:0]         stack_ff;
   logic               advance;
   logic               a_valid_ff;
   logic [8:0]         a_row_ff;
   logic [8:0]         a_col_ff;
   logic               valid_ff [SB_DEPTH];
   sideband_type       sb_ff [SB_DEPTH];
   sideband_type       sb_in;
   sideband_type       sb_out;
   logic [8:0]         sector_plus_one;
   logic [18:0]        k1_wide;
   logic [DIV_WIDTH-1:0] lon_dividend;
   logic [DIV_WIDTH-1:0] lat_dividend;
   logic [31:0]        lon_quot;
   logic [31:0]        lat_quot;
   logic [31:0]        lat_phase;
   logic signed [31:0] cos_lat;
   logic signed [31:0] sin_lat;
   logic signed [31:0] cos_lon;
   logic signed [31:0] sin_lon;
   logic [15:0]        pos_x;
   logic [15:0]        pos_y;
   logic [15:0]        pos_z;

   logic               rsp_valid_ff;
   logic [15:0]        rsp_pos_x_ff;
   logic [15:0]        rsp_pos_y_ff;
   logic [15:0]        rsp_pos_z_ff;
   logic               rsp_in_range_ff;
   logic               rsp_upper_ff;
   logic               rsp_lower_ff;
   logic [16:0]        rsp_tl_ff;
   logic [16:0]        rsp_bl_ff;
   logic [16:0]        rsp_tr_ff;
   logic [16:0]        rsp_br_ff;

   // configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sector_ff <= SECTOR_RESET;
         stack_ff  <= STACK_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SECTOR_COUNT: begin
               sector_ff <= (csr_data < SECTOR_MIN) ? SECTOR_MIN :
                            (csr_data > COUNT_MAX) ? COUNT_MAX : csr_data;
            end
            CSR_STACK_COUNT: begin
               stack_ff <= (csr_data < STACK_MIN) ? STACK_MIN :
                           (csr_data > COUNT_MAX) ? COUNT_MAX : csr_data;
            end
            default: begin
               sector_ff <= sector_ff;
            end
         endcase
      end
   end

   // flow control
   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;

   // capture
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_row_ff <= req_stack_row;
         a_col_ff <= req_sector_column;
      end
   end

   // grid checks and top left index
   assign sector_plus_one = sector_ff + 9'd1;
   assign k1_wide         = 19'(a_row_ff * sector_plus_one) + 19'(a_col_ff);

   always_comb begin
      sb_in.in_range = (a_row_ff <= stack_ff) && (a_col_ff <= sector_ff);
      sb_in.quad     = (a_row_ff < stack_ff) && (a_col_ff < sector_ff);
      sb_in.upper    = sb_in.quad && (a_row_ff != 9'd0);
      sb_in.lower    = sb_in.quad && (a_row_ff != 9'(stack_ff - 9'd1));
      sb_in.k1       = k1_wide[16:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (advance) begin
         valid_ff[0] <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sb_ff[0] <= sb_in;
      end
   end

   for (genvar n = 1; n < SB_DEPTH; n++) begin : g_sb
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[n] <= 1'b0;
         end else if (advance) begin
            valid_ff[n] <= valid_ff[n-1];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            sb_ff[n] <= sb_ff[n-1];
         end
      end
   end

   assign sb_out = sb_ff[SB_DEPTH-1];

   // angle phases
   assign lon_dividend = {1'b0, a_col_ff, 32'd0} | {34'd0, sector_ff[8:1]};
   assign lat_dividend = {2'b00, a_row_ff, 31'd0} | {34'd0, stack_ff[8:1]};

   uvs_divider u_lon_div (
      .clock    (clock),
      .advance  (advance),
      .divisor  (sector_ff),
      .dividend (lon_dividend),
      .quotient (lon_quot)
   );

   uvs_divider u_lat_div (
      .clock    (clock),
      .advance  (advance),
      .divisor  (stack_ff),
      .dividend (lat_dividend),
      .quotient (lat_quot)
   );

   assign lat_phase = LAT_TOP_PHASE - lat_quot;

   uvs_cordic u_lat_cordic (
      .clock   (clock),
      .advance (advance),
      .phase   (lat_phase),
      .cos_out (cos_lat),
      .sin_out (sin_lat)
   );

   uvs_cordic u_lon_cordic (
      .clock   (clock),
      .advance (advance),
      .phase   (lon_quot),
      .cos_out (cos_lon),
      .sin_out (sin_lon)
   );

   uvs_coord u_coord (
      .clock   (clock),
      .advance (advance),
      .cos_lat (cos_lat),
      .sin_lat (sin_lat),
      .cos_lon (cos_lon),
      .sin_lon (sin_lon),
      .pos_x   (pos_x),
      .pos_y   (pos_y),
      .pos_z   (pos_z)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= valid_ff[SB_DEPTH-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_in_range_ff <= sb_out.in_range;
         rsp_upper_ff    <= sb_out.upper;
         rsp_lower_ff    <= sb_out.lower;
         rsp_pos_x_ff    <= sb_out.in_range ? pos_x : 16'd0;
         rsp_pos_y_ff    <= sb_out.in_range ? pos_y : 16'd0;
         rsp_pos_z_ff    <= sb_out.in_range ? pos_z : 16'd0;
         rsp_tl_ff       <= sb_out.in_range ? sb_out.k1 : 17'd0;
         rsp_bl_ff       <= sb_out.quad ? 17'(sb_out.k1 + 17'(sector_plus_one)) : 17'd0;
         rsp_tr_ff       <= sb_out.quad ? 17'(sb_out.k1 + 17'd1) : 17'd0;
         rsp_br_ff       <= sb_out.quad ?
                            17'(sb_out.k1 + 17'(sector_plus_one) + 17'd1) : 17'd0;
      end
   end

   assign rsp_valid                = rsp_valid_ff;
   assign rsp_pos_x                = rsp_pos_x_ff;
   assign rsp_pos_y                = rsp_pos_y_ff;
   assign rsp_pos_z                = rsp_pos_z_ff;
   assign rsp_in_range             = rsp_in_range_ff;
   assign rsp_upper_triangle_valid = rsp_upper_ff;
   assign rsp_lower_triangle_valid = rsp_lower_ff;
   assign rsp_corner_top_left      = rsp_tl_ff;
   assign rsp_corner_bottom_left   = rsp_bl_ff;
   assign rsp_corner_top_right     = rsp_tr_ff;
   assign rsp_corner_bottom_right  = rsp_br_ff;

`ifndef SYNTH
   // out of grid gives an all-zero transaction
   a_out_of_grid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_in_range_ff |->
         rsp_pos_x_ff == 16'd0 && rsp_pos_y_ff == 16'd0 && rsp_pos_z_ff == 16'd0 &&
         !rsp_upper_ff && !rsp_lower_ff && rsp_tl_ff == 17'd0)
      else $error("out of grid transaction not cleared");

   // a triangle flag needs a quad, whose right corner follows the left one
   a_quad_corners: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_upper_ff || rsp_lower_ff) |->
         rsp_in_range_ff && rsp_tr_ff == 17'(rsp_tl_ff + 17'd1))
      else $error("triangle flag without consistent quad corners");

   // an accepted transaction enters the capture stage
   a_capture: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> a_valid_ff)
      else $error("accepted transaction not captured");

   // a held output freezes the last pipeline stage
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> $stable(valid_ff[SB_DEPTH-1]))
      else $error("pipeline moved under output stall");
`endif

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the UV sphere vertex and quad index generator.
// ----------------------------------------------------------------------------
// Drives grid points in bursts under several sector and stack counts while
// the result side stalls on its own pattern. A fixed-point model of the
// sphere (phase division, cordic rotation, rounding and saturation) predicts
// every result. The model also gives the quad corners and the triangle flags.
// Each result is compared field by field, in order, with the oldest
// prediction. A short table of directed points runs first. Rows of the table
// whose result is easy to read off carry a typed-in expected value as well.
// ----------------------------------------------------------------------------
module tb_top;
   import uvs_pkg::*;

   typedef struct packed {
      logic [15:0] x, y, z;
      logic        in_range, upper, lower;
      logic [16:0] k1, k2, k1p, k2p;
   } vertex_type;

   typedef struct {
      logic [8:0] row, col;
      bit         typed;
      vertex_type want;
   } point_row_type;

   logic clock = 0, reset = 1;
   logic req_valid = 0, rsp_stall = 0, csr_valid = 0, csr_index = CSR_SECTOR_COUNT;
   logic [8:0] req_stack_row = 0, req_sector_column = 0, csr_data = 0;
   logic req_stall, rsp_valid, csr_ready;
   logic [15:0] rsp_pos_x, rsp_pos_y, rsp_pos_z;
   logic rsp_in_range, rsp_upper_triangle_valid, rsp_lower_triangle_valid;
   logic [16:0] rsp_corner_top_left, rsp_corner_bottom_left;
   logic [16:0] rsp_corner_top_right, rsp_corner_bottom_right;

   uv_sphere_vertex_index_generator dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("FAILED: results differ");
      $finish;
   end

   int unsigned sectors_reg = SECTOR_RESET, stacks_reg = STACK_RESET;
   vertex_type  vertex_queue[$];
   int          errors = 0;

   function automatic longint fshift(longint v, int k);
      return v >>> k;
   endfunction

   function automatic void sin_cos(logic [31:0] phase, output longint c, output longint s);
      longint x, y, z, dx, dy, cc, ss;
      cc = 64'sd1 << 30;
      ss = 0;
      if (phase[29:0] != 0) begin
         x = GAIN_INV;
         y = 0;
         z = phase[29:0];
         for (int k = 0; k < CORDIC_ITERS; k++) begin
            dx = fshift(y, k);
            dy = fshift(x, k);
            if (z >= 0) begin
               x -= dx; y += dy; z -= ATAN_TURNS[k];
            end else begin
               x += dx; y -= dy; z += ATAN_TURNS[k];
            end
         end
         cc = x;
         ss = y;
      end
      case (phase[31:30])
         2'd0: begin c = cc;  s = ss;  end
         2'd1: begin c = -ss; s = cc;  end
         2'd2: begin c = -cc; s = -ss; end
         default: begin c = ss; s = -cc; end
      endcase
   endfunction

   function automatic logic [15:0] coord(longint v, int k);
      longint lim;
      lim = 64'sd1 << COORD_FRAC_BITS;
      v = fshift(v + (64'sd1 << (k - 1)), k);
      if (v > lim) v = lim;
      if (v < -lim) v = -lim;
      return v[15:0];
   endfunction

   function automatic vertex_type sphere_point(logic [8:0] i, logic [8:0] j);
      vertex_type r;
      longint unsigned s, t, k1, k2;
      logic [31:0] lon, lat;
      longint cl, sl, cn, sn;
      r = '0;
      s = sectors_reg < 3 ? 3 : sectors_reg > MAX_DIVISIONS ? MAX_DIVISIONS : sectors_reg;
      t = stacks_reg < 2 ? 2 : stacks_reg > MAX_DIVISIONS ? MAX_DIVISIONS : stacks_reg;
      if (i > t || j > s) return r;
      lon = 32'(((64'(j) << 32) + s / 2) / s);
      lat = LAT_TOP_PHASE - 32'(((64'(i) << 31) + t / 2) / t);
      sin_cos(lat, cl, sl);
      sin_cos(lon, cn, sn);
      r.x = coord(cl * cn, 60 - COORD_FRAC_BITS);
      r.y = coord(cl * sn, 60 - COORD_FRAC_BITS);
      r.z = coord(sl, 30 - COORD_FRAC_BITS);
      r.in_range = 1;
      k1 = i * (s + 1) + j;
      k2 = k1 + s + 1;
      r.k1 = k1[16:0];
      if (i < t && j < s) begin
         r.upper = i != 0;
         r.lower = i != t - 1;
         r.k2 = k2[16:0];
         r.k1p = 17'(k1 + 1);
         r.k2p = 17'(k2 + 1);
      end
      return r;
   endfunction

   task automatic report(string what, longint got, longint want);
      errors++;
      $display("mismatch %s: got %0h want %0h", what, got, want);
   endtask

   // result side: stall pattern and checking
   int stall_mode = 0;
   always @(posedge clock) begin
      if (!reset) begin
         case (stall_mode)
            0: rsp_stall <= 0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            default: rsp_stall <= ($urandom_range(0, 9) < 7);
         endcase
         if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
      end
      if (rsp_valid && !rsp_stall && !reset) begin
         vertex_type w;
         if (vertex_queue.size() == 0) begin
            report("unexpected transaction", 0, 0);
         end else begin
            w = vertex_queue.pop_front();
            if (rsp_pos_x !== w.x) report("pos_x", rsp_pos_x, w.x);
            if (rsp_pos_y !== w.y) report("pos_y", rsp_pos_y, w.y);
            if (rsp_pos_z !== w.z) report("pos_z", rsp_pos_z, w.z);
            if (rsp_in_range !== w.in_range) report("in_range", rsp_in_range, w.in_range);
            if (rsp_upper_triangle_valid !== w.upper)
               report("upper_triangle_valid", rsp_upper_triangle_valid, w.upper);
            if (rsp_lower_triangle_valid !== w.lower)
               report("lower_triangle_valid", rsp_lower_triangle_valid, w.lower);
            if (rsp_corner_top_left !== w.k1) report("corner_top_left", rsp_corner_top_left, w.k1);
            if (rsp_corner_bottom_left !== w.k2)
               report("corner_bottom_left", rsp_corner_bottom_left, w.k2);
            if (rsp_corner_top_right !== w.k1p)
               report("corner_top_right", rsp_corner_top_right, w.k1p);
            if (rsp_corner_bottom_right !== w.k2p)
               report("corner_bottom_right", rsp_corner_bottom_right, w.k2p);
         end
      end
   end

   task automatic write_reg(logic idx, logic [8:0] value);
      @(posedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      if (idx == CSR_SECTOR_COUNT) sectors_reg = value;
      else stacks_reg = value;
   endtask

   // send one point; valid stays high when another follows in the burst
   int burst_left = 0;
   task automatic send_point(logic [8:0] i, logic [8:0] j);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_valid <= 0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      req_valid         <= 1;
      req_stack_row     <= i;
      req_sector_column <= j;
      vertex_queue.insert(vertex_queue.size(), sphere_point(i, j));
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain;
      int n;
      req_valid <= 0;
      burst_left = 0;
      n = 0;
      while (vertex_queue.size() != 0 && n < 200000) begin
         @(posedge clock);
         n++;
      end
      repeat (60) @(posedge clock);
   endtask

   point_row_type directed[$];

   function automatic void add_row(logic [8:0] i, logic [8:0] j, bit typed, vertex_type w);
      point_row_type p;
      p.row = i; p.col = j; p.typed = typed; p.want = w;
      directed.insert(directed.size(), p);
   endfunction

   function automatic logic [8:0] rand_coord(int unsigned count);
      int unsigned r;
      r = $urandom_range(0, 19);
      if (r == 0) return 9'($urandom_range(0, 511));
      if (r == 1) return 9'(count + 1);
      if (r == 2) return 9'(count);
      return 9'($urandom_range(0, count > 255 ? 255 : count));
   endfunction

   initial begin
      logic [8:0] settings[8][2];
      vertex_type w;
      settings = '{
         '{9'd3, 9'd2}, '{9'd256, 9'd256}, '{9'd8, 9'd4}, '{9'd0, 9'd511},
         '{9'd511, 9'd1}, '{9'd17, 9'd9}, '{9'd100, 9'd50}, '{9'd36, 9'd18}};
      repeat (11) @(posedge clock);
      reset <= 0;

      // north pole under reset counts: z is one, x and y zero
      w = '0; w.z = 16'sd16384; w.in_range = 1; w.lower = 1;
      w.k2 = 37; w.k1p = 1; w.k2p = 38;
      add_row(0, 0, 1, w);
      // south pole, last row gives no quad
      w = '0; w.z = -16'sd16384; w.in_range = 1; w.k1 = 18 * 37;
      add_row(18, 0, 1, w);
      // outside the grid: all zeros
      add_row(19, 0, 1, '0);
      add_row(0, 37, 1, '0);
      add_row(511, 511, 1, '0);
      add_row(9'h1AA, 9'h055, 1, '0);
      add_row(9'h155, 9'h0AA, 1, '0);
      add_row(9, 0, 0, '0);
      add_row(9, 9, 0, '0);
      add_row(9, 18, 0, '0);
      add_row(9, 27, 0, '0);
      add_row(9, 36, 0, '0);
      add_row(17, 35, 0, '0);
      add_row(1, 5, 0, '0);
      add_row(18, 36, 0, '0);
      foreach (directed[n]) begin
         send_point(directed[n].row, directed[n].col);
         if (directed[n].typed && vertex_queue[$] !== directed[n].want)
            report("typed row", n, 0);
      end
      drain();

      for (int p = 0; p < 8; p++) begin
         write_reg(CSR_SECTOR_COUNT, settings[p][0]);
         write_reg(CSR_STACK_COUNT, settings[p][1]);
         if (p == 0) write_reg(CSR_SECTOR_COUNT, 9'd4);
         for (int n = 0; n < 240; n++) begin
            int unsigned s, t;
            s = sectors_reg < 3 ? 3 : sectors_reg > 256 ? 256 : sectors_reg;
            t = stacks_reg < 2 ? 2 : stacks_reg > 256 ? 256 : stacks_reg;
            send_point(rand_coord(t), rand_coord(s));
         end
         drain();
      end

      if (errors == 0 && vertex_queue.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end
endmodule

// ===== uv_sphere_vertex_index_generator.f =====
hw/rtl/uvs_pkg.sv
hw/rtl/uvs_divider.sv
hw/rtl/uvs_cordic.sv
hw/rtl/uvs_coord.sv
hw/rtl/uv_sphere_vertex_index_generator.sv
test/tb_top.sv
